>>> design/trapezoid_membership_raster_top_defines.svh
// assertion macros for the trapezoid membership raster
// used by trapezoid_membership_raster_top; define NO_ASSERTIONS to drop the checks
`ifndef TRAPEZOID_MEMBERSHIP_RASTER_TOP_DEFINES_SVH
`define TRAPEZOID_MEMBERSHIP_RASTER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// check that is off while reset is held
`define TMR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tmr assertion failed");

// check that also runs through reset
`define TMR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tmr assertion failed");

`else

`define TMR_ASSERT(label, clk, rst_n, prop)
`define TMR_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

>>> design/tmr_pkg.sv
// shared types and constants of the trapezoid membership raster
// no dependencies; imported by every module of the block
package tmr_pkg;

    localparam int COL_W   = 8;              // column index and corner width
    localparam int ROW_W   = 6;              // row count register width
    localparam int CNT_W   = 9;              // column count register width
    localparam int MASK_W  = 32;             // column mask width
    localparam int NUM_W   = COL_W + ROW_W;  // rows times column distance
    localparam int IDX_W   = 3;              // register index width
    localparam int CFG_W   = 9;              // widest register
    localparam int FILL_W  = 1 << ROW_W;     // span of any row count

    localparam int DEF_MAX_ROWS = 32;
    localparam int MAX_COLUMNS  = 256;
    localparam int RST_ROWS     = 32;
    localparam int RST_COLUMNS  = 256;

    typedef enum logic [1:0] {
        ST_OK,
        ST_CORNER_RANGE,
        ST_UNORDERED,
        ST_COL_RANGE
    } t_status;

    typedef enum logic [IDX_W-1:0] {
        REG_CORNER_A,
        REG_CORNER_B,
        REG_CORNER_C,
        REG_CORNER_D,
        REG_ROW_COUNT,
        REG_COLUMN_COUNT
    } t_reg_idx;

    // settings as seen by the datapath
    typedef struct packed {
        logic [COL_W-1:0] a;
        logic [COL_W-1:0] b;
        logic [COL_W-1:0] c;
        logic [COL_W-1:0] d;
        logic [ROW_W-1:0] m;
        logic [CNT_W-1:0] n;
        t_status          status;
    } t_cfg;

    // item in flight between the front end, the divider and the mask stage
    typedef struct packed {
        t_status          status;
        logic             full;
        logic [NUM_W-1:0] rem;
        logic [COL_W-1:0] den;
        logic [ROW_W-1:0] q;
    } t_div_item;

endpackage

>>> design/tmr_cfg.sv
// settings registers and the values derived from them
// depends on tmr_pkg
module tmr_cfg import tmr_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_cfg             o_cfg
);

    logic [COL_W-1:0] r_corner_a;
    logic [COL_W-1:0] r_corner_b;
    logic [COL_W-1:0] r_corner_c;
    logic [COL_W-1:0] r_corner_d;
    logic [ROW_W-1:0] r_row_count;
    logic [CNT_W-1:0] r_column_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner_a     <= '0;
            r_corner_b     <= '0;
            r_corner_c     <= '0;
            r_corner_d     <= '0;
            r_row_count    <= ROW_W'(RST_ROWS);
            r_column_count <= CNT_W'(RST_COLUMNS);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_CORNER_A:     r_corner_a     <= i_cfg_data[COL_W-1:0];
                REG_CORNER_B:     r_corner_b     <= i_cfg_data[COL_W-1:0];
                REG_CORNER_C:     r_corner_c     <= i_cfg_data[COL_W-1:0];
                REG_CORNER_D:     r_corner_d     <= i_cfg_data[COL_W-1:0];
                REG_ROW_COUNT:    r_row_count    <= i_cfg_data[ROW_W-1:0];
                REG_COLUMN_COUNT: r_column_count <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_cfg.a = r_corner_a;
        o_cfg.b = r_corner_b;
        o_cfg.c = r_corner_c;
        o_cfg.d = r_corner_d;

        o_cfg.m = r_row_count;
        if ((ROW_W + 1)'(r_row_count) > (ROW_W + 1)'(MAX_ROWS)) begin
            o_cfg.m = ROW_W'(MAX_ROWS);
        end

        o_cfg.n = r_column_count;
        if (32'(r_column_count) > MAX_COLUMNS) begin
            o_cfg.n = CNT_W'(MAX_COLUMNS);
        end

        // corner range check wins over the order check
        if ({1'b0, r_corner_a} >= o_cfg.n || {1'b0, r_corner_b} >= o_cfg.n ||
            {1'b0, r_corner_c} >= o_cfg.n || {1'b0, r_corner_d} >= o_cfg.n) begin
            o_cfg.status = ST_CORNER_RANGE;
        end else if (r_corner_a > r_corner_b || r_corner_b > r_corner_c ||
                     r_corner_c > r_corner_d) begin
            o_cfg.status = ST_UNORDERED;
        end else begin
            o_cfg.status = ST_OK;
        end
    end

endmodule

>>> design/tmr_front.sv
// front end: classifies the column against the corners, then scales the
// edge distance by the row count; two register stages, depends on tmr_pkg
module tmr_front import tmr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [COL_W-1:0] i_col,
    output logic             o_valid,
    input  logic             i_ready,
    output t_div_item        o_item
);

    localparam logic [COL_W-1:0] ONE = {{(COL_W-1){1'b0}}, 1'b1};

    // stage 1: region and edge distance
    logic             r1_v;
    t_status          r1_status;
    logic             r1_full;
    logic [COL_W-1:0] r1_x;
    logic [COL_W-1:0] r1_den;

    t_status          n1_status;
    logic             n1_full;
    logic [COL_W-1:0] n1_x;
    logic [COL_W-1:0] n1_den;

    // stage 2: scaled numerator
    logic             r2_v;
    t_div_item        r2_item;
    logic [NUM_W-1:0] n2_num;

    logic w_rdy1;
    logic w_rdy2;

    assign w_rdy2  = !r2_v || i_ready;
    assign w_rdy1  = !r1_v || w_rdy2;
    assign o_ready = w_rdy1;

    always_comb begin
        n1_status = i_cfg.status;
        if (i_cfg.status == ST_OK && {1'b0, i_col} >= i_cfg.n) begin
            n1_status = ST_COL_RANGE;
        end
        // outside the trapezoid: zero over one gives height zero
        n1_full = 1'b0;
        n1_x    = '0;
        n1_den  = ONE;
        if (n1_status == ST_OK && i_col >= i_cfg.a && i_col <= i_cfg.d) begin
            if (i_col < i_cfg.b) begin
                n1_x   = i_col - i_cfg.a;
                n1_den = i_cfg.b - i_cfg.a;
            end else if (i_col <= i_cfg.c) begin
                n1_full = 1'b1;
            end else begin
                n1_x   = i_cfg.d - i_col;
                n1_den = i_cfg.d - i_cfg.c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_rdy1) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r1_status <= n1_status;
            r1_full   <= n1_full;
            r1_x      <= n1_x;
            r1_den    <= n1_den;
        end
    end

    assign n2_num = {{COL_W{1'b0}}, i_cfg.m} * {{ROW_W{1'b0}}, r1_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_rdy2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r1_v) begin
            r2_item.status <= r1_status;
            r2_item.full   <= r1_full;
            r2_item.rem    <= n2_num;
            r2_item.den    <= r1_den;
            r2_item.q      <= '0;
        end
    end

    assign o_valid = r2_v;
    assign o_item  = r2_item;

endmodule

>>> design/tmr_div.sv
// pipelined restoring divider, one quotient bit per register stage
// depends on tmr_pkg
module tmr_div import tmr_pkg::*; #(
    parameter int QW = 5
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_div_item i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_div_item o_item
);

    logic [QW:0] w_v;
    logic [QW:0] w_rdy;
    t_div_item   w_item [QW+1];

    assign w_v[0]    = i_valid;
    assign w_item[0] = i_item;
    assign w_rdy[QW] = i_ready;
    assign o_ready   = w_rdy[0];
    assign o_valid   = w_v[QW];
    assign o_item    = w_item[QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int BIT = QW - 1 - k;

        logic             r_v;
        t_div_item        r_item;
        t_div_item        n_item;
        logic [NUM_W-1:0] w_dsh;

        // quotient stays below the row count, so the top bit is QW-1
        assign w_dsh = NUM_W'(w_item[k].den) << BIT;

        always_comb begin
            n_item = w_item[k];
            if (w_item[k].rem >= w_dsh) begin
                n_item.rem    = w_item[k].rem - w_dsh;
                n_item.q[BIT] = 1'b1;
            end
        end

        assign w_rdy[k] = !r_v || w_rdy[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k] && w_v[k]) begin
                r_item <= n_item;
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_item[k+1] = r_item;
    end

endmodule

>>> design/tmr_mask.sv
// turns the column height into the row mask and holds the output item
// depends on tmr_pkg
module tmr_mask import tmr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ROW_W-1:0]  i_m,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_div_item         i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [MASK_W-1:0] o_mask,
    output t_status           o_status
);

    logic              r_v;
    logic [MASK_W-1:0] r_mask;
    t_status           r_status;

    logic [ROW_W-1:0]  w_h;
    logic [FILL_W-1:0] w_low_m;
    logic [FILL_W-1:0] w_low_e;
    logic [MASK_W-1:0] n_mask;

    assign o_ready = !r_v || i_ready;

    // rows m-h .. m-1 set: difference of two low masks
    always_comb begin
        w_h     = i_item.full ? i_m : i_item.q;
        w_low_m = (FILL_W'(1) << i_m) - FILL_W'(1);
        w_low_e = (FILL_W'(1) << (i_m - w_h)) - FILL_W'(1);
        n_mask  = '0;
        if (i_item.status == ST_OK) begin
            n_mask = MASK_W'(w_low_m ^ w_low_e);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mask   <= n_mask;
            r_status <= i_item.status;
        end
    end

    assign o_valid  = r_v;
    assign o_mask   = r_mask;
    assign o_status = r_status;

endmodule

>>> design/trapezoid_membership_raster_top.sv
// Trapezoid membership raster: each input item is a column index, and the
// result item is that column's row mask (row 0 at the top, filled from the
// bottom row m-1 upward) with a status in tuser. The block takes one item per
// clock while the output is not stalled and returns results in order. Its
// register stages, with QW = clog2(MAX_ROWS), are two front-end stages
// (classify, scale by the row count), QW divider stages that each settle one
// quotient bit of the edge slope, and the output register. The default
// MAX_ROWS is 32. Write settings only while no item is in flight.
// depends on tmr_pkg and trapezoid_membership_raster_top_defines.svh
`include "trapezoid_membership_raster_top_defines.svh"

module trapezoid_membership_raster_top import tmr_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [7:0]       i_s_axis_tdata,   // [7:0] column_index
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [31:0] column_mask
    output logic [1:0]       o_m_axis_tuser    // [1:0] status
);

    localparam int QW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    t_cfg      w_cfg;
    logic      w_fe_valid;
    logic      w_fe_ready;
    t_div_item w_fe_item;
    logic      w_dv_valid;
    logic      w_dv_ready;
    t_div_item w_dv_item;
    t_status   w_status;

    tmr_cfg #(
        .MAX_ROWS (MAX_ROWS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    tmr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_col   (i_s_axis_tdata[COL_W-1:0]),
        .o_valid (w_fe_valid),
        .i_ready (w_fe_ready),
        .o_item  (w_fe_item)
    );

    tmr_div #(
        .QW (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fe_valid),
        .o_ready (w_fe_ready),
        .i_item  (w_fe_item),
        .o_valid (w_dv_valid),
        .i_ready (w_dv_ready),
        .o_item  (w_dv_item)
    );

    tmr_mask u_mask (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_m      (w_cfg.m),
        .i_valid  (w_dv_valid),
        .o_ready  (w_dv_ready),
        .i_item   (w_dv_item),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_mask   (o_m_axis_tdata),
        .o_status (w_status)
    );

    assign o_m_axis_tuser = w_status;

    // an error status never carries mask bits
    `TMR_ASSERT(a_err_mask_zero, i_clk, i_rst_n, (o_m_axis_tvalid && o_m_axis_tuser != ST_OK) |-> (o_m_axis_tdata == '0))

    // no row at or below the row count is ever set
    `TMR_ASSERT(a_rows_in_range, i_clk, i_rst_n, o_m_axis_tvalid |-> ((FILL_W'(o_m_axis_tdata) >> w_cfg.m) == '0))

    // with the output empty every stage can move, so input is taken
    `TMR_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_m_axis_tvalid |-> o_s_axis_tready)

    // reset empties the output
    `TMR_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

>>> sim/tb_trapezoid_membership_raster_top.sv
// testbench for trapezoid_membership_raster_top: column requests go in on the slave stream,
// row masks and status come back on the master stream and are checked against a local model
// depends on tmr_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_trapezoid_membership_raster_top import tmr_pkg::*; ();

    typedef struct packed {
        logic [31:0] mask;
        t_status     status;
    } t_column_result;

    // indexes past the last register, writes there must be dropped
    localparam logic [IDX_W-1:0] IDX_SPARE_FIRST = 3'd6;
    localparam logic [IDX_W-1:0] IDX_SPARE_LAST  = 3'd7;
    localparam int RANDOM_COLUMNS = 1300;
    localparam int CALM_COLUMNS   = 150;
    localparam int SETTLE_CYCLES  = 20;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    logic [7:0]       i_s_axis_tdata;   // [7:0] column_index
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready;
    logic [31:0]      o_m_axis_tdata;   // [31:0] column_mask
    logic [1:0]       o_m_axis_tuser;   // [1:0] status

    // local copy of the settings
    logic [7:0] corner_a_reg, corner_b_reg, corner_c_reg, corner_d_reg;
    logic [5:0] row_reg;
    logic [8:0] col_count_reg;

    t_column_result column_expect[$];
    t_column_result want;
    int  columns_sent;
    int  results_seen;
    int  mismatch_count;
    int  setting_count;
    bit  idle_on;
    bit  stall_on;

    trapezoid_membership_raster_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_column_result predict_column(input logic [7:0] col);
        t_column_result res;
        int unsigned m, n, a, b, c, d, h, x;
        logic [63:0] ones;
        m = 32'(row_reg);
        if (m > DEF_MAX_ROWS)
            m = DEF_MAX_ROWS;
        n = 32'(col_count_reg);
        if (n > MAX_COLUMNS)
            n = MAX_COLUMNS;
        a = 32'(corner_a_reg);
        b = 32'(corner_b_reg);
        c = 32'(corner_c_reg);
        d = 32'(corner_d_reg);
        x = 32'(col);
        h = 0;
        res.mask = '0;
        if (a >= n || b >= n || c >= n || d >= n) begin
            res.status = ST_CORNER_RANGE;
        end else if (a > b || b > c || c > d) begin
            res.status = ST_UNORDERED;
        end else if (x >= n) begin
            res.status = ST_COL_RANGE;
        end else begin
            res.status = ST_OK;
            if (x < a || x > d)
                h = 0;
            else if (x < b)
                h = (m * (x - a)) / (b - a);
            else if (x <= c)
                h = m;
            else
                h = (m * (d - x)) / (d - c);
            // rows m-h .. m-1 filled, counted from the top
            ones = (64'd1 << h) - 64'd1;
            ones = ones << (m - h);
            res.mask = ones[31:0];
        end
        return res;
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        case (idx)
            REG_CORNER_A:     corner_a_reg  = val[7:0];
            REG_CORNER_B:     corner_b_reg  = val[7:0];
            REG_CORNER_C:     corner_c_reg  = val[7:0];
            REG_CORNER_D:     corner_d_reg  = val[7:0];
            REG_ROW_COUNT:    row_reg       = val[5:0];
            REG_COLUMN_COUNT: col_count_reg = val[8:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_shape(input int a, input int b, input int c, input int d,
                             input int rows, input int cols);
        write_reg(REG_CORNER_A, CFG_W'(a));
        write_reg(REG_CORNER_B, CFG_W'(b));
        write_reg(REG_CORNER_C, CFG_W'(c));
        write_reg(REG_CORNER_D, CFG_W'(d));
        write_reg(REG_ROW_COUNT, CFG_W'(rows));
        write_reg(REG_COLUMN_COUNT, CFG_W'(cols));
        setting_count++;
    endtask

    task automatic send_column(input logic [7:0] col);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = col;
        do @(posedge i_clk); while (!o_s_axis_tready);
        column_expect.push_back(predict_column(col));
        columns_sent++;
    endtask

    // stop sending and hold until every expected mask is back
    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (column_expect.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_reset_defaults();
        // corners all zero after reset: column 0 is a full plateau
        setting_count++;
        send_column(8'd0);
        send_column(8'd1);
        send_column(8'd255);
        drain_results();
    endtask

    task automatic test_slopes();
        set_shape(10, 20, 30, 50, 32, 64);
        send_column(8'd9);
        send_column(8'd10);
        send_column(8'd15);
        send_column(8'd19);
        send_column(8'd25);
        send_column(8'd31);
        send_column(8'd45);
        send_column(8'd50);
        send_column(8'd51);
        send_column(8'd64);
        drain_results();
    endtask

    task automatic test_special_cases();
        // corner past the column count
        set_shape(10, 20, 30, 45, 32, 40);
        send_column(8'd20);
        drain_results();
        // corners out of order
        set_shape(25, 20, 30, 45, 32, 64);
        send_column(8'd20);
        drain_results();
        // no rows, then a row count that saturates
        set_shape(10, 20, 30, 50, 0, 64);
        send_column(8'd25);
        drain_results();
        write_reg(REG_ROW_COUNT, 9'd63);
        send_column(8'd15);
        drain_results();
        // zero columns makes every corner out of range
        write_reg(REG_COLUMN_COUNT, 9'd0);
        send_column(8'd0);
        drain_results();
        // column count above the maximum saturates, corner at the last column
        set_shape(0, 128, 200, 255, 7, 9'h1FF);
        send_column(8'd255);
        drain_results();
        // both edges degenerate into a single column
        set_shape(5, 5, 5, 5, 1, 16);
        send_column(8'd5);
        send_column(8'd4);
        drain_results();
        // spare indexes must leave the settings alone
        write_reg(IDX_SPARE_FIRST, 9'h1FF);
        write_reg(IDX_SPARE_LAST, 9'h000);
        send_column(8'd6);
        drain_results();
    endtask

    task automatic test_random_phases();
        int sent, phase_len, k, j, r, n_reg, n_eff, top, lo, hi, rows, tmp;
        int cv[4];
        bit paused;
        logic [7:0] col;
        sent = 0;
        paused = 1'b0;
        while (sent < RANDOM_COLUMNS) begin
            drain_results();
            if (RANDOM_COLUMNS - sent <= CALM_COLUMNS) begin
                idle_on  = 1'b0;
                stall_on = 1'b0;
                phase_len = RANDOM_COLUMNS - sent;
            end else begin
                idle_on  = ($urandom_range(0, 3) != 0);
                stall_on = ($urandom_range(0, 3) != 0);
                phase_len = $urandom_range(40, 120);
            end
            r = $urandom_range(0, 19);
            if (r == 0)
                n_reg = 0;
            else if (r == 1)
                n_reg = 1;
            else if (r <= 3)
                n_reg = $urandom_range(257, 511);
            else if (r == 4)
                n_reg = 256;
            else
                n_reg = $urandom_range(2, 256);
            n_eff = (n_reg > MAX_COLUMNS) ? MAX_COLUMNS : n_reg;
            top = (n_eff > 0) ? n_eff - 1 : 0;
            for (k = 0; k < 4; k++)
                cv[k] = $urandom_range(0, top);
            for (k = 0; k < 3; k++)
                for (j = 0; j < 3 - k; j++)
                    if (cv[j] > cv[j+1]) begin
                        tmp = cv[j];
                        cv[j] = cv[j+1];
                        cv[j+1] = tmp;
                    end
            // a few broken shapes: out of order or a corner past the grid
            r = $urandom_range(0, 19);
            if (r == 0) begin
                k = $urandom_range(0, 2);
                tmp = cv[k];
                cv[k] = cv[k+1];
                cv[k+1] = tmp;
            end else if (r == 1) begin
                cv[3] = $urandom_range(top, 255);
            end
            r = $urandom_range(0, 19);
            if (r == 0)
                rows = 0;
            else if (r == 1)
                rows = 1;
            else if (r == 2)
                rows = 32;
            else if (r <= 4)
                rows = $urandom_range(33, 63);
            else
                rows = $urandom_range(1, 32);
            set_shape(cv[0], cv[1], cv[2], cv[3], rows, n_reg);
            lo = (cv[0] > 2) ? cv[0] - 2 : 0;
            hi = (cv[3] < 253) ? cv[3] + 2 : 255;
            for (k = 0; k < phase_len; k++) begin
                r = $urandom_range(0, 9);
                if (r < 5 && lo <= hi)
                    col = 8'($urandom_range(lo, hi));
                else if (r < 9 && n_eff > 0)
                    col = 8'($urandom_range(0, top));
                else
                    col = 8'($urandom_range(0, 255));
                send_column(col);
                sent++;
                // hold off once mid-phase until the pipeline is empty
                if (!paused && setting_count > 12 && k == phase_len / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end
        drain_results();
    endtask

    // output side: random bursts of backpressure
    initial begin
        i_m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_on && $urandom_range(0, 9) == 0) begin
                i_m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 17)) @(negedge i_clk);
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (column_expect.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with nothing expected: mask %h status %0d",
                             $realtime, o_m_axis_tdata, o_m_axis_tuser);
            end else begin
                want = column_expect.pop_front();
                if (o_m_axis_tdata !== want.mask || o_m_axis_tuser !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch: mask %h status %0d, expected mask %h status %0d",
                                 $realtime, o_m_axis_tdata, o_m_axis_tuser,
                                 want.mask, want.status);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        corner_a_reg    = '0;
        corner_b_reg    = '0;
        corner_c_reg    = '0;
        corner_d_reg    = '0;
        row_reg         = 6'(RST_ROWS);
        col_count_reg   = 9'(RST_COLUMNS);
        columns_sent    = 0;
        results_seen    = 0;
        mismatch_count  = 0;
        setting_count   = 0;
        idle_on         = 1'b1;
        stall_on        = 1'b1;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_slopes();
        test_special_cases();
        test_random_phases();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (column_expect.size() != 0) begin
            mismatch_count += column_expect.size();
            $display("%0d expected masks never arrived", column_expect.size());
        end
        $display("sent %0d column requests over %0d register settings, %0d results checked",
                 columns_sent, setting_count, results_seen);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
